### rtl/midpc_pkg.sv
// shared types and constants for the masked id packet classifier
// no dependencies
`default_nettype none
package midpc_pkg;
    localparam int NUM_CLASSES = 64;
    localparam int ALIGN_BYTES = 8;
    localparam int CW          = $clog2(NUM_CLASSES);
    localparam int SZW         = 18;
    localparam logic [31:0] SPARE_BYTES = 32'd3000;
    localparam logic [15:0] LEN_BIAS    = 16'd8;
    localparam int IN_W  = 168;
    localparam int OUT_W = 184;

    localparam logic [1:0] ACT_CLASSIFY = 2'd0;
    localparam logic [1:0] ACT_WRITE    = 2'd1;
    localparam logic [1:0] ACT_BEGIN    = 2'd2;
    localparam logic [1:0] ACT_NONE     = 2'd3;

    localparam logic CFG_MEM_SIZE = 1'b0;
    localparam logic CFG_OVERHEAD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECODE, ST_RD, ST_CMP, ST_CNT_RD, ST_CNT_WR, ST_EXEC, ST_FIN
    } t_state;

    typedef struct packed {
        logic load_in;
        logic rd;
        logic cmp;
        logic cnt_rd;
        logic cnt_wr;
        logic exec;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       hit;
        logic       scan_last;
        logic       out_free;
    } t_status;
endpackage
`default_nettype wire

### rtl/masked_id_packet_classifier_unit.sv
// classify scans 1 up to NUM_CLASSES-1 entries, highest index first, and stops at the first hit;
// with no hit the result is class 0; other actions take no scan
// the next input transfer is taken only after the result is loaded into the output register;
// a result held back by the receiver stalls the input for as long
// reset: synchronous active low; only entry 0 valid, counters zero, budget zero, overhead 24
// top level; depends on midpc_pkg, midpc_ctrl, midpc_dp
`default_nettype none
module masked_id_packet_classifier_unit import midpc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_index, entry_id, entry_mask, entry_store, header_low, header_high,
    // error_word, one pad bit
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    // action
    input  wire logic [1:0]        s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // class_index, stored, packet_ident, spin_number, data_size, quality,
    // class_total, class_kept, memory_remaining, two pad bits
    output logic [OUT_W-1:0]       m_axis_tdata,
    // configuration writes: 0 memory_size, 1 header_overhead
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [30:0]       i_cfg_data
);
    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: one transfer in, scan and update (classify) or action step (others), one transfer out
    midpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath with table, counters and output register
    midpc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_action (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );
endmodule
`default_nettype wire

### rtl/midpc_ctrl.sv
// sequencer for the classifier: scan, counter update, other actions and result hand-off
// depends on midpc_pkg
`default_nettype none
module midpc_ctrl import midpc_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_status.action == ACT_CLASSIFY) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_EXEC;
                end
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_status.hit || i_status.scan_last) begin
                    n_state = ST_CNT_RD;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state = ST_CNT_WR;
            end
            ST_CNT_WR: begin
                o_cmd.cnt_wr = 1'b1;
                n_state = ST_FIN;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### rtl/midpc_dp.sv
// datapath: class table, per-class counters, storage budget, output register
// depends on midpc_pkg
`default_nettype none
module midpc_dp import midpc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IN_W-1:0]  i_in_data,
    input  wire logic [1:0]       i_in_action,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [30:0]      i_cfg_data,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_W-1:0]      o_out_data,
    input  wire t_cmd             i_cmd,
    output t_status               o_status
);
    // captured item
    logic [1:0]  r_action;
    logic [5:0]  r_eidx;
    logic [31:0] r_eid, r_emask, r_lo, r_hi, r_err;
    logic        r_estore;

    // configuration
    logic [30:0] r_mem_size;
    logic [7:0]  r_ovh;
    logic [30:0] r_left;

    // class table
    logic [31:0] mem_id   [NUM_CLASSES];
    logic [31:0] mem_mask [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_vld, r_may;
    logic [31:0] r_id_q, r_mask_q;
    logic [CW-1:0] r_idx, r_cmp_idx, r_cls;

    // counters
    logic [31:0] mem_tot  [NUM_CLASSES];
    logic [31:0] mem_kept [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_cnt_vld;
    logic [31:0] r_tot_q, r_kept_q;
    logic [SZW-1:0] r_size;

    // staged result
    logic [OUT_W-1:0] r_res, r_out;
    logic             r_out_vld;

    logic [31:0] w_ident;
    logic [15:0] w_spin, w_dsize, w_qual;
    logic        w_hit;
    logic [7:0]  w_eidx8;
    logic        w_eok;
    logic [CW-1:0] w_eaddr;
    logic [31:0] w_size32, w_need;
    logic        w_keep;
    logic [31:0] w_tot, w_kept;

    assign w_ident = {r_lo[7:0], r_hi[23:16], r_hi[31:24], r_lo[15:8]};
    assign w_spin  = r_hi[15:0];
    assign w_dsize = r_lo[31:16] - LEN_BIAS;
    assign w_qual  = r_err[31:16];
    assign w_hit   = r_vld[r_cmp_idx] && (r_id_q == (w_ident & r_mask_q));
    assign w_eidx8 = 8'(r_eidx);
    assign w_eok   = 9'(w_eidx8) < 9'(NUM_CLASSES);
    assign w_eaddr = w_eidx8[CW-1:0];

    assign w_size32 = ((32'(w_dsize) + 32'(r_ovh)) / ALIGN_BYTES + 32'd1) * ALIGN_BYTES;
    assign w_need   = 32'(r_size) + SPARE_BYTES + 32'(r_ovh);
    assign w_keep   = r_may[r_cls] && (32'(r_left) > w_need);
    assign w_tot    = (r_cnt_vld[r_cls] ? r_tot_q : 32'd0) + 32'd1;
    assign w_kept   = (r_cnt_vld[r_cls] ? r_kept_q : 32'd0) + 32'(w_keep);

    assign o_status.action    = r_action;
    assign o_status.hit       = w_hit;
    assign o_status.scan_last = (r_idx == CW'(1));
    assign o_status.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_eidx   <= i_in_data[5:0];
            r_eid    <= i_in_data[37:6];
            r_emask  <= i_in_data[69:38];
            r_estore <= i_in_data[70];
            r_lo     <= i_in_data[102:71];
            r_hi     <= i_in_data[134:103];
            r_err    <= i_in_data[166:135];
        end
        if (i_cmd.rd) begin
            r_id_q    <= mem_id[r_idx];
            r_mask_q  <= mem_mask[r_idx];
            r_cmp_idx <= r_idx;
        end
        if (i_cmd.exec && r_action == ACT_WRITE && w_eok) begin
            mem_id[w_eaddr]   <= r_eid;
            mem_mask[w_eaddr] <= r_emask;
        end
        if (i_cmd.cnt_rd) begin
            r_tot_q  <= mem_tot[r_cls];
            r_kept_q <= mem_kept[r_cls];
            r_size   <= SZW'(w_size32);
        end
        if (i_cmd.cnt_wr) begin
            mem_tot[r_cls]  <= w_tot;
            mem_kept[r_cls] <= w_kept;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action   <= ACT_CLASSIFY;
            r_mem_size <= '0;
            r_ovh      <= 8'd24;
            r_left     <= '0;
            r_vld      <= NUM_CLASSES'(1);
            r_may      <= '1;
            r_cnt_vld  <= '0;
            r_idx      <= '0;
            r_cls      <= '0;
            r_res      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MEM_SIZE: r_mem_size <= i_cfg_data;
                    CFG_OVERHEAD: r_ovh      <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_in) begin
                r_action <= i_in_action;
                r_idx    <= CW'(NUM_CLASSES - 1);
            end
            if (i_cmd.cmp) begin
                if (w_hit) begin
                    r_cls <= r_cmp_idx;
                end else if (r_idx == CW'(1)) begin
                    r_cls <= '0;
                end else begin
                    r_idx <= r_idx - CW'(1);
                end
            end
            if (i_cmd.cnt_wr) begin
                r_cnt_vld[r_cls] <= 1'b1;
                if (w_keep) begin
                    r_left <= r_left - 31'(r_size);
                end
                r_res <= {2'b00, (w_keep ? r_left - 31'(r_size) : r_left),
                          w_kept, w_tot, w_qual, w_dsize, w_spin, w_ident,
                          w_keep, 6'(r_cls)};
            end
            if (i_cmd.exec) begin
                if (r_action == ACT_WRITE && w_eok) begin
                    r_vld[w_eaddr] <= 1'b1;
                    r_may[w_eaddr] <= r_estore;
                end
                if (r_action == ACT_BEGIN) begin
                    r_cnt_vld <= '0;
                    r_left    <= r_mem_size;
                    r_res     <= {2'b00, r_mem_size, 151'd0};
                end else begin
                    r_res     <= {2'b00, r_left, 151'd0};
                end
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire
